// ----- rtl/pcd_pkg.sv -----
package pcd_pkg;
    localparam int MaxPoints = 16;
    localparam int IdxW = 4;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ZERO_RATE = 2'd1;
    localparam logic [1:0] ST_ZERO_TOTAL = 2'd2;
    localparam logic [1:0] ST_NO_SEGMENT = 2'd3;
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam logic CFG_PERIOD = 1'b0;
    localparam logic CFG_POINTS = 1'b1;
    typedef struct packed {
        logic [31:0] t;
        logic [31:0] r;
        logic [47:0] tot;
    } t_entry;
    // divider request and answer
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } t_div_req;
    typedef struct packed {
        logic        done;
        logic [63:0] quo;
        logic [63:0] rem;
    } t_div_rsp;
endpackage

// ----- rtl/pcd_div.sv -----
module pcd_div
    import pcd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    // restoring divider, one quotient bit per cycle
    logic [63:0] r_num, r_den, r_quo, n_num, n_quo;
    logic [64:0] r_rem, n_rem, w_sh;
    logic [6:0]  r_cnt;
    logic        r_busy, r_done;

    always_comb begin
        w_sh = {r_rem[63:0], r_num[63]};
        n_num = {r_num[62:0], 1'b0};
        if (w_sh >= {1'b0, r_den}) begin
            n_rem = w_sh - {1'b0, r_den};
            n_quo = {r_quo[62:0], 1'b1};
        end else begin
            n_rem = w_sh;
            n_quo = {r_quo[62:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_quo <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= n_num;
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem[63:0];
endmodule

// ----- rtl/pcd_mul.sv -----
module pcd_mul
    import pcd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_done,
    output logic        o_ov,
    output logic [63:0] o_p
);
    // 64x64 product from 32x32 partials, one per cycle, with overflow flag
    logic [63:0] r_a, r_b;
    logic [2:0]  r_step;
    logic        r_busy, r_done, r_ov;
    logic [63:0] r_acc;
    logic [63:0] w_pp;
    logic [31:0] w_x, w_y;
    logic [64:0] w_sum;

    always_comb begin
        unique case (r_step[1:0])
            2'd0: begin w_x = r_a[31:0];  w_y = r_b[31:0];  end
            2'd1: begin w_x = r_a[63:32]; w_y = r_b[31:0];  end
            2'd2: begin w_x = r_a[31:0];  w_y = r_b[63:32]; end
            default: begin w_x = r_a[63:32]; w_y = r_b[63:32]; end
        endcase
        w_pp = 64'(w_x) * 64'(w_y);
        if (r_step[1:0] == 2'd0) w_sum = {1'b0, w_pp};
        else w_sum = {1'b0, r_acc} + {1'b0, w_pp[31:0], 32'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a  <= i_a;
            r_b  <= i_b;
            r_ov <= 1'b0;
        end else if (r_busy) begin
            r_acc <= w_sum[63:0];
            if (r_step[1:0] == 2'd3) begin
                if (w_pp != 64'd0) r_ov <= 1'b1;
            end else if (r_step[1:0] != 2'd0) begin
                if (w_sum[64] || w_pp[63:32] != 32'd0) r_ov <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_ov   = r_ov;
    assign o_p    = r_acc;
endmodule

// ----- rtl/periodic_curve_delay.sv -----
// periodic_curve_delay
// a write goes straight to its result beat once it is accepted; a full query runs three
// serial divisions, a multiply and two segment walks before its result; status errors end sooner
// one item at a time; the next beat is taken once the result leaves
// reset: synchronous active low; registers return to period 9000000, 2 points
module periodic_curve_delay
    import pcd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command
    input  logic [0:0]   s_axis_tuser,
    // entry_index[3:0], break_time[35:4], break_rate[67:36], break_total[115:68],
    // start_time[147:116], amount[195:148]
    input  logic [199:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // delay[63:0], status[65:64]
    output logic [71:0]  m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_LAST  = 14'b00000000000010,
        S_PHASE = 14'b00000000000100,
        S_W1RD  = 14'b00000000001000,
        S_W1    = 14'b00000000010000,
        S_MUL   = 14'b00000000100000,
        S_DIVA  = 14'b00000001000000,
        S_MULW  = 14'b00000010000000,
        S_W2RD  = 14'b00000100000000,
        S_W2    = 14'b00001000000000,
        S_DIVB  = 14'b00010000000000,
        S_FIN   = 14'b00100000000000,
        S_OUT   = 14'b01000000000000,
        S_PREV  = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_entry mem [MaxPoints];
    t_entry r_rd, r_prev;
    logic [IdxW-1:0] r_addr;
    logic [31:0] r_period, r_start, r_phase;
    logic [4:0]  r_points;
    logic [47:0] r_amt, r_total, r_offset;
    logic [63:0] r_pos, r_neg, r_eff, r_d, r_up, r_down, r_whole, r_rem;
    logic        r_ov, r_tail;
    logic [63:0] r_delay;
    logic [1:0]  r_status;
    logic [4:0]  w_n;
    logic [IdxW-1:0] w_last;
    t_div_req w_dreq;
    t_div_rsp w_drsp;
    logic w_mstart, w_mdone, w_mov;
    logic [63:0] w_mp;
    logic r_divsel; // 0 phase or amount split, 1 inverse
    logic r_div2;
    logic w_acc;
    logic [64:0] w_s1;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_n = (r_points < 5'd2) ? 5'd2 :
                 (r_points > 5'(MaxPoints)) ? 5'(MaxPoints) : r_points;
    assign w_last = 4'(w_n - 5'd1);

    pcd_div u_div (.i_clk, .i_rst_n, .i_req(w_dreq), .o_rsp(w_drsp));
    pcd_mul u_mul (.i_clk, .i_rst_n, .i_start(w_mstart), .i_a(r_whole), .i_b(r_eff),
                   .o_done(w_mdone), .o_ov(w_mov), .o_p(w_mp));

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= 32'd9000000;
            r_points <= 5'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PERIOD: r_period <= i_cfg_data;
                default:    r_points <= i_cfg_data[4:0];
            endcase
        end
    end

    // breakpoint memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_acc && s_axis_tuser[0] == CMD_WRITE)
            mem[s_axis_tdata[3:0]] <= '{t: s_axis_tdata[35:4], r: s_axis_tdata[67:36],
                                        tot: s_axis_tdata[115:68]};
        r_rd <= mem[r_addr];
    end

    // segment tests on entry pair (prev, cur)
    logic [63:0] w_prod;
    logic        w_hit1, w_hit2, w_above;
    always_comb begin
        w_hit1 = (r_prev.t <= r_phase) && (r_rd.t >= r_phase);
        w_prod = 64'(r_prev.r) * 64'(r_rd.t - r_phase);
        w_hit2 = ({16'd0, r_prev.tot} <= r_d) && ({16'd0, r_rd.tot} >= r_d);
        w_above = {16'd0, r_prev.tot} > r_d;
        w_s1 = {1'b0, r_pos} + {1'b0, r_up};
    end

    always_comb begin
        w_dreq = '0;
        w_mstart = 1'b0;
        if (r_state == S_PHASE && !r_div2) begin
            w_dreq.start = 1'b1;
            w_dreq.num = 64'(r_start);
            w_dreq.den = r_eff;
        end else if (r_state == S_W1 && r_div2) begin
            w_dreq.start = 1'b1;
            w_dreq.num = 64'(r_amt);
            w_dreq.den = 64'(r_total);
        end else if (r_state == S_W2 && r_divsel) begin
            w_dreq.start = 1'b1;
            w_dreq.num = r_up;
            w_dreq.den = r_down;
        end
        if (r_state == S_MUL) w_mstart = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            m_axis_tvalid <= 1'b0;
            r_div2 <= 1'b0;
            r_divsel <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: if (w_acc) begin
                    r_start <= s_axis_tdata[147:116];
                    r_amt   <= s_axis_tdata[195:148];
                    r_eff   <= (r_period == 32'd0) ? 64'h1_0000_0000 : 64'(r_period);
                    r_pos <= '0; r_neg <= '0; r_ov <= 1'b0;
                    r_up <= '0; r_down <= '0;
                    r_div2 <= 1'b0; r_divsel <= 1'b0;
                    r_delay <= '0; r_status <= ST_OK;
                    r_addr <= w_last;
                    if (s_axis_tuser[0] == CMD_WRITE) r_state <= S_OUT;
                    else r_state <= S_LAST;
                end
                S_LAST: r_state <= S_PHASE; // memory read in flight
                S_PHASE: begin
                    if (!r_div2) begin
                        r_total <= r_rd.tot;
                        r_div2 <= 1'b1;
                    end else if (w_drsp.done) begin
                        r_phase <= w_drsp.rem[31:0];
                        if (r_total == 48'd0) begin
                            r_status <= ST_ZERO_TOTAL;
                            r_state <= S_OUT;
                        end else begin
                            r_addr <= '0;
                            r_div2 <= 1'b0;
                            r_state <= S_W1RD;
                        end
                    end
                end
                S_W1RD: begin
                    r_addr <= r_addr + 4'd1;
                    r_state <= S_PREV;
                end
                S_PREV: begin
                    r_prev <= r_rd;
                    r_state <= S_W1;
                end
                S_W1: begin
                    if (r_div2) begin
                        r_state <= S_DIVA;
                    end else if (w_hit1) begin
                        r_offset <= (64'(r_prev.tot) > w_prod) ?
                                    48'(64'(r_prev.tot) - w_prod) : '0;
                        r_div2 <= 1'b1;
                    end else if (5'(r_addr) + 5'd1 >= w_n) begin
                        r_status <= ST_NO_SEGMENT;
                        r_state <= S_OUT;
                    end else begin
                        r_prev <= r_rd;
                        r_state <= S_W1RD;
                    end
                end
                S_DIVA: if (w_drsp.done) begin
                    r_whole <= w_drsp.quo;
                    r_rem <= w_drsp.rem;
                    r_addr <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_MULW;
                S_MULW: if (w_mdone) begin
                    r_ov <= w_mov;
                    r_pos <= w_mov ? 64'd0 : w_mp;
                    if (r_rem + 64'(r_offset) > 64'(r_total)) begin
                        r_d <= r_rem + 64'(r_offset) - 64'(r_total);
                        r_tail <= 1'b1;
                    end else begin
                        r_d <= r_rem + 64'(r_offset);
                        r_tail <= 1'b0;
                    end
                    // entry 0 is being read, entry 1 goes out next
                    r_addr <= 4'd1;
                    r_state <= S_W2RD;
                end
                S_W2RD: begin
                    r_prev <= r_rd;
                    r_state <= S_W2;
                    r_divsel <= 1'b0;
                end
                S_W2: begin
                    if (r_divsel) begin
                        r_state <= S_DIVB;
                    end else if (w_hit2) begin
                        if (r_rd.r == 32'd0) begin
                            r_status <= ST_ZERO_RATE; r_state <= S_OUT;
                        end else begin
                            r_up <= r_d - 64'(r_prev.tot);
                            r_down <= 64'(r_rd.r);
                            r_divsel <= 1'b1;
                            r_div2 <= 1'b0;
                            r_start <= r_rd.t;
                        end
                    end else if (w_above) begin
                        if (r_prev.r == 32'd0) begin
                            r_status <= ST_ZERO_RATE; r_state <= S_OUT;
                        end else begin
                            r_up <= 64'(r_prev.tot) - r_d;
                            r_down <= 64'(r_prev.r);
                            r_divsel <= 1'b1;
                            r_div2 <= 1'b1;
                            r_start <= r_rd.t;
                        end
                    end else if (5'(r_addr) + 5'd1 >= w_n) begin
                        r_status <= ST_NO_SEGMENT;
                        r_state <= S_OUT;
                    end else begin
                        r_addr <= r_addr + 4'd1;
                        r_state <= S_W2RD;
                    end
                end
                S_DIVB: if (w_drsp.done) begin
                    // r_div2 tells which form: 0 up gets quotient, 1 down gets it
                    if (!r_div2) begin
                        r_up <= 64'(r_start) + w_drsp.quo;
                        r_down <= '0;
                    end else begin
                        r_up <= 64'(r_start);
                        r_down <= w_drsp.quo;
                    end
                    if (r_tail) begin
                        r_neg <= '0;
                        if ({1'b0, r_pos} + {1'b0, r_eff - 64'(r_phase)} > 65'hFFFF_FFFF_FFFF_FFFF)
                            r_ov <= 1'b1;
                        r_pos <= r_pos + (r_eff - 64'(r_phase));
                    end else begin
                        r_neg <= 64'(r_phase);
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (r_ov || w_s1[64]) r_delay <= '1;
                    else if (w_s1[63:0] > r_neg + r_down) r_delay <= w_s1[63:0] - (r_neg + r_down);
                    else r_delay <= '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!m_axis_tvalid) m_axis_tvalid <= 1'b1;
                    else if (m_axis_tready) begin
                        m_axis_tvalid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = {6'd0, r_status, (r_status == ST_OK) ? r_delay : 64'd0};

    // results only appear in the output state
    a_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_state == S_OUT) else $error("tvalid outside output");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("ready with result held");
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_status != ST_OK) |-> m_axis_tdata[63:0] == 64'd0)
        else $error("nonzero delay on error");
endmodule
